// ===== src/wsd_pkg.sv =====
// Shared types, constants and helpers for the WebSocket frame deframer.
`default_nettype none

package wsd_pkg;

  // Width of the frame length counters; extended lengths saturate at all ones.
  localparam int LEN_BITS = 64;

  // Depth of the result queue between parser and output side (power of two).
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  // Header bit fields and length escapes
  localparam logic [7:0] HDR_TOP_BIT  = 8'h80;
  localparam logic [3:0] OPCODE_MASK  = 4'hF;
  localparam logic [6:0] LEN7_MASK    = 7'h7F;
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;

  // Opcodes
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Action classes
  localparam logic [2:0] ACT_TEXT   = 3'd0;
  localparam logic [2:0] ACT_CLOSE  = 3'd1;
  localparam logic [2:0] ACT_PING   = 3'd2;
  localparam logic [2:0] ACT_PONG   = 3'd3;
  localparam logic [2:0] ACT_IGNORE = 3'd4;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [3:0] frame_opcode;
    logic       fin_flag;
    logic [2:0] action;
    logic       is_last;
  } wsd_result_t;

  function automatic logic [2:0] action_of(input logic [3:0] op);
    logic [2:0] act;
    case (op)
      OP_TEXT:  act = ACT_TEXT;
      OP_CLOSE: act = ACT_CLOSE;
      OP_PING:  act = ACT_PING;
      OP_PONG:  act = ACT_PONG;
      default:  act = ACT_IGNORE;
    endcase
    return act;
  endfunction

endpackage

`default_nettype wire

// ===== src/wsd_parser.sv =====
// Front end: header parser and payload unmasking, one byte per cycle while accept is high.
`default_nettype none

module wsd_parser
  import wsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        accept,
  input  wire logic [7:0]  rx_byte,
  output logic             push,
  output wsd_result_t      result
);

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASKKEY = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  phase_t                phase, phase_next;
  logic                  hs_done;
  logic [2:0]            hdr_idx, hdr_idx_next;
  logic [3:0]            held_opcode, held_opcode_next;
  logic                  held_fin, held_fin_next;
  logic                  held_masked, held_masked_next;
  logic                  ext_long, ext_long_next;
  logic [LEN_BITS-1:0]   len_acc, len_acc_next;
  logic [LEN_BITS-1:0]   bytes_rem, bytes_rem_next;
  logic [31:0]           mask_key, mask_key_next;
  logic [1:0]            mask_pos, mask_pos_next;

  // length-known step, shared by second header byte and extended length
  logic                  len_done;
  logic [LEN_BITS-1:0]   done_len;
  logic                  done_masked;

  logic [2:0]            idx_inc;
  logic [LEN_BITS-1:0]   acc_shifted;
  logic [7:0]            key_byte;
  logic [LEN_BITS-1:0]   rem_dec;

  assign idx_inc     = hdr_idx + 3'd1;
  assign acc_shifted = (len_acc[LEN_BITS-1 -: 8] != 8'd0) ? '1 :
                       {len_acc[LEN_BITS-9:0], rx_byte};
  assign rem_dec     = (bytes_rem != '0) ? (bytes_rem - LEN_BITS'(1)) : bytes_rem;

  always_comb begin
    case (mask_pos)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next        = phase;
    hdr_idx_next      = hdr_idx;
    held_opcode_next  = held_opcode;
    held_fin_next     = held_fin;
    held_masked_next  = held_masked;
    ext_long_next     = ext_long;
    len_acc_next      = len_acc;
    bytes_rem_next    = bytes_rem;
    mask_key_next     = mask_key;
    mask_pos_next     = mask_pos;
    len_done          = 1'b0;
    done_len          = len_acc;
    done_masked       = held_masked;
    push              = 1'b0;
    result.payload_byte = 8'd0;
    result.has_byte     = 1'b0;
    result.frame_opcode = held_opcode;
    result.fin_flag     = held_fin;
    result.action       = action_of(held_opcode);
    result.is_last      = 1'b1;

    if (accept && hs_done) begin
      case (phase)
        PH_FIRST: begin
          held_fin_next    = (rx_byte & HDR_TOP_BIT) != 8'd0;
          held_opcode_next = rx_byte[3:0] & OPCODE_MASK;
          mask_pos_next    = 2'd0;
          mask_key_next    = 32'd0;
          hdr_idx_next     = 3'd0;
          phase_next       = PH_SECOND;
        end
        PH_SECOND: begin
          held_masked_next = (rx_byte & HDR_TOP_BIT) != 8'd0;
          hdr_idx_next     = 3'd0;
          len_acc_next     = '0;
          if ((rx_byte[6:0] & LEN7_MASK) == LEN_EXT16) begin
            ext_long_next = 1'b0;
            phase_next    = PH_EXTLEN;
          end else if ((rx_byte[6:0] & LEN7_MASK) == LEN_EXT64) begin
            ext_long_next = 1'b1;
            phase_next    = PH_EXTLEN;
          end else begin
            len_acc_next = LEN_BITS'(rx_byte[6:0]);
            len_done     = 1'b1;
            done_len     = LEN_BITS'(rx_byte[6:0]);
            done_masked  = held_masked_next;
          end
        end
        PH_EXTLEN: begin
          len_acc_next = acc_shifted;
          hdr_idx_next = idx_inc;
          if (idx_inc == (ext_long ? 3'd0 : 3'd2)) begin
            len_done    = 1'b1;
            done_len    = acc_shifted;
            done_masked = held_masked;
          end
        end
        PH_MASKKEY: begin
          mask_key_next = {mask_key[23:0], rx_byte};
          hdr_idx_next  = idx_inc;
          if (idx_inc[2]) begin
            hdr_idx_next = 3'd0;
            if (bytes_rem == '0) begin
              phase_next = PH_FIRST;
              push       = 1'b1;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          mask_pos_next       = mask_pos + 2'd1;
          bytes_rem_next      = rem_dec;
          push                = 1'b1;
          result.payload_byte = held_masked ? (rx_byte ^ key_byte) : rx_byte;
          result.has_byte     = 1'b1;
          result.is_last      = (rem_dec == '0);
          if (rem_dec == '0) begin
            phase_next = PH_FIRST;
          end
        end
        default: begin
          phase_next = PH_FIRST;
        end
      endcase

      if (len_done) begin
        bytes_rem_next = done_len;
        hdr_idx_next   = 3'd0;
        if (done_masked) begin
          phase_next = PH_MASKKEY;
        end else if (done_len == '0) begin
          phase_next = PH_FIRST;
          push       = 1'b1;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_FIRST;
      hs_done     <= 1'b0;
      hdr_idx     <= 3'd0;
      held_opcode <= 4'd0;
      held_fin    <= 1'b0;
      held_masked <= 1'b0;
      ext_long    <= 1'b0;
      len_acc     <= '0;
      bytes_rem   <= '0;
      mask_key    <= 32'd0;
      mask_pos    <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        hs_done <= cfg_wr_data;
      end
      phase       <= phase_next;
      hdr_idx     <= hdr_idx_next;
      held_opcode <= held_opcode_next;
      held_fin    <= held_fin_next;
      held_masked <= held_masked_next;
      ext_long    <= ext_long_next;
      len_acc     <= len_acc_next;
      bytes_rem   <= bytes_rem_next;
      mask_key    <= mask_key_next;
      mask_pos    <= mask_pos_next;
    end
  end

`ifndef SYNTHESIS
  a_push_needs_hs: assert property (@(posedge clk) disable iff (rst)
    push |-> (accept && hs_done))
    else $error("result pushed without an accepted byte under handshake");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (push && result.is_last) |=> (phase == PH_FIRST))
    else $error("frame end did not return parser to first header byte");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (push && !result.has_byte) |-> result.is_last)
    else $error("empty-frame word not flagged last");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_rem != '0))
    else $error("payload phase with no bytes remaining");
`endif

endmodule

`default_nettype wire

// ===== src/wsd_fifo.sv =====
// Short result queue decoupling the parser from the output handshake.
`default_nettype none

module wsd_fifo
  import wsd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wsd_result_t       push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              not_empty,
  output wsd_result_t       head
);

  wsd_result_t          mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer: byte parser plus output queue.
`default_nettype none

// WebSocket frame deframer. Takes one received stream byte per word on the
// input channel and parses frames: first header byte (FIN, opcode), second
// header byte (MASK, 7-bit length), optional 16- or 64-bit big-endian
// extended length, optional 4-byte mask key, then payload. Each payload byte
// leaves as one output word, unmasked with key byte (index mod 4), together
// with opcode, FIN, action class and a last flag; an empty frame gives one
// word with has_byte low. Header bytes give no word. While handshake_done is
// clear every input byte is taken and dropped; the parse position is kept.
// Rate: one byte per cycle sustained while the queue has room. A byte is
// parsed in the cycle it is accepted and its word is registered into a
// two-entry queue whose head drives the output. in_ready drops only when
// the queue is full, i.e. after the output side has stalled for two words.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: handshake_done
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  // received byte stream
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  // parsed payload words
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       payload_byte,
  output logic             has_byte,
  output logic [3:0]       frame_opcode,
  output logic             fin_flag,
  output logic [2:0]       action,
  output logic             is_last
);

  logic         accept;
  logic         push;
  logic         q_full;
  wsd_result_t  parsed;
  wsd_result_t  head;

  // Every byte needs queue room up front, since any byte may produce a word.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  wsd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .push        (push),
    .result      (parsed)
  );

  wsd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (parsed),
    .full      (q_full),
    .pop       (out_ready),
    .not_empty (out_valid),
    .head      (head)
  );

  assign payload_byte = head.payload_byte;
  assign has_byte     = head.has_byte;
  assign frame_opcode = head.frame_opcode;
  assign fin_flag     = head.fin_flag;
  assign action       = head.action;
  assign is_last      = head.is_last;

endmodule

`default_nettype wire
